// File: rtl/mpool_pkg.sv
// Shared constants and types for the streaming max-pooling block.
`timescale 1ns / 1ps
`default_nettype none

package mpool_pkg;

  // Sizing of the line buffer, the counters and the sample word.
  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // Configuration register widths are fixed by the register map.
  localparam int CFG_DIM_W  = 11;
  localparam int CFG_POOL_W = 5;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = CFG_IDX_W'(2);

  localparam logic [CFG_DIM_W-1:0]  RST_MAP_ROWS  = CFG_DIM_W'(28);
  localparam logic [CFG_DIM_W-1:0]  RST_MAP_COLS  = CFG_DIM_W'(28);
  localparam logic [CFG_POOL_W-1:0] RST_POOL_SIZE = CFG_POOL_W'(2);

  // Window side limit and the in-window counter width.
  localparam int POOL_MAX = 16;
  localparam int WIN_W    = $clog2(POOL_MAX);

  // Width that holds any effective map dimension, including MAX_ROWS/MAX_COLS.
  localparam int DIM_A = ($clog2(MAX_ROWS + 1) > CFG_DIM_W) ? $clog2(MAX_ROWS + 1) : CFG_DIM_W;
  localparam int DIM_W = ($clog2(MAX_COLS + 1) > DIM_A) ? $clog2(MAX_COLS + 1) : DIM_A;

  // Depths of the small queues.
  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // One finished window row span, handed from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [COL_W-1:0]              oc;
    logic                          first_row;
    logic                          band_end;
    logic                          map_done;
  } span_t;

  // One pooled result waiting on the output side.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          map_done;
  } result_t;

  // Handshake between the span queue and the back end.
  typedef struct packed {
    logic  valid;
    span_t head;
  } span_q_t;

endpackage

`default_nettype wire

// File: rtl/mpool_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/mpool_front.sv
// Front end: configuration registers, position counters and row-span maxima.
`timescale 1ns / 1ps
`default_nettype none

module mpool_front (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      cfg_wr_en,
  input  wire logic [mpool_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [mpool_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
  input  wire logic                                      in_push,
  input  wire logic signed [mpool_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic                                           in_full,
  input  wire logic                                      q_full,
  output logic                                           q_push,
  output mpool_pkg::span_t                               q_entry
);

  localparam int DW = mpool_pkg::DIM_W;
  localparam int PW = mpool_pkg::CFG_POOL_W;

  logic [mpool_pkg::CFG_DIM_W-1:0]  rows_r, cols_r;
  logic [PW-1:0]                    pool_r;
  logic [mpool_pkg::ROW_W-1:0]      row_pos_r, row_pos_nxt;
  logic [mpool_pkg::COL_W-1:0]      col_pos_r, col_pos_nxt;
  logic [mpool_pkg::COL_W-1:0]      oc_r, oc_nxt;
  logic [mpool_pkg::WIN_W-1:0]      riw_r, riw_nxt;
  logic [mpool_pkg::WIN_W-1:0]      ciw_r, ciw_nxt;
  logic signed [mpool_pkg::SAMPLE_BITS-1:0] wm_r, wm_nxt;

  logic [DW-1:0] rows_eff, cols_eff;
  logic [PW-1:0] pool_eff;
  logic accept, cfg_known;
  logic row_end, col_end, ciw_last, riw_last, span_end, band_end;

  // Zero acts as one, oversize clamps to the limit.
  always_comb begin
    rows_eff = DW'(rows_r);
    if (rows_r == '0) begin
      rows_eff = DW'(1);
    end else if (DW'(rows_r) > DW'(mpool_pkg::MAX_ROWS)) begin
      rows_eff = DW'(mpool_pkg::MAX_ROWS);
    end
    cols_eff = DW'(cols_r);
    if (cols_r == '0) begin
      cols_eff = DW'(1);
    end else if (DW'(cols_r) > DW'(mpool_pkg::MAX_COLS)) begin
      cols_eff = DW'(mpool_pkg::MAX_COLS);
    end
    pool_eff = pool_r;
    if (pool_r == '0) begin
      pool_eff = PW'(1);
    end else if (pool_r > PW'(mpool_pkg::POOL_MAX)) begin
      pool_eff = PW'(mpool_pkg::POOL_MAX);
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  assign row_end  = (DW'(col_pos_r) + DW'(1)) == cols_eff;
  assign col_end  = (DW'(row_pos_r) + DW'(1)) == rows_eff;
  assign ciw_last = (PW'(ciw_r) + PW'(1)) == pool_eff;
  assign riw_last = (PW'(riw_r) + PW'(1)) == pool_eff;
  assign span_end = ciw_last || row_end;
  assign band_end = riw_last || col_end;

  always_comb begin
    wm_nxt = wm_r;
    if (ciw_r == '0 || in_sample > wm_r) begin
      wm_nxt = in_sample;
    end
  end

  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    oc_nxt      = oc_r;
    riw_nxt     = riw_r;
    ciw_nxt     = ciw_r;
    if (row_end) begin
      col_pos_nxt = '0;
      ciw_nxt     = '0;
      oc_nxt      = '0;
      if (col_end) begin
        row_pos_nxt = '0;
        riw_nxt     = '0;
      end else begin
        row_pos_nxt = row_pos_r + mpool_pkg::ROW_W'(1);
        riw_nxt     = riw_last ? '0 : riw_r + mpool_pkg::WIN_W'(1);
      end
    end else begin
      col_pos_nxt = col_pos_r + mpool_pkg::COL_W'(1);
      ciw_nxt     = ciw_last ? '0 : ciw_r + mpool_pkg::WIN_W'(1);
      oc_nxt      = ciw_last ? oc_r + mpool_pkg::COL_W'(1) : oc_r;
    end
  end

  assign q_push            = accept && span_end;
  assign q_entry.value     = wm_nxt;
  assign q_entry.oc        = oc_r;
  assign q_entry.first_row = (riw_r == '0);
  assign q_entry.band_end  = band_end;
  assign q_entry.map_done  = row_end && col_end;

  assign cfg_known = (cfg_index == mpool_pkg::CFG_MAP_ROWS) ||
                     (cfg_index == mpool_pkg::CFG_MAP_COLS) ||
                     (cfg_index == mpool_pkg::CFG_POOL_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= mpool_pkg::RST_MAP_ROWS;
      cols_r    <= mpool_pkg::RST_MAP_COLS;
      pool_r    <= mpool_pkg::RST_POOL_SIZE;
      row_pos_r <= '0;
      col_pos_r <= '0;
      oc_r      <= '0;
      riw_r     <= '0;
      ciw_r     <= '0;
      wm_r      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mpool_pkg::CFG_MAP_ROWS:  rows_r <= mpool_pkg::CFG_DIM_W'(cfg_wr_data);
        mpool_pkg::CFG_MAP_COLS:  cols_r <= mpool_pkg::CFG_DIM_W'(cfg_wr_data);
        mpool_pkg::CFG_POOL_SIZE: pool_r <= cfg_wr_data[PW-1:0];
        default: ;
      endcase
      // Restart the map on any known register write.
      if (cfg_known) begin
        row_pos_r <= '0;
        col_pos_r <= '0;
        oc_r      <= '0;
        riw_r     <= '0;
        ciw_r     <= '0;
        wm_r      <= '0;
      end
    end else if (accept) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      oc_r      <= oc_nxt;
      riw_r     <= riw_nxt;
      ciw_r     <= ciw_nxt;
      wm_r      <= wm_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpool_queue.sv
// Short queue of row spans between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module mpool_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mpool_pkg::span_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output mpool_pkg::span_q_t     status
);

  mpool_pkg::span_t slots_r [mpool_pkg::MQ_DEPTH];
  logic [mpool_pkg::MQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mpool_pkg::MQ_CNT_W-1:0] count_r;
  logic do_push, do_pop;

  assign full         = count_r == mpool_pkg::MQ_CNT_W'(mpool_pkg::MQ_DEPTH);
  assign status.valid = count_r != '0;
  assign status.head  = slots_r[rd_ptr_r];
  assign do_push      = push && !full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + mpool_pkg::MQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + mpool_pkg::MQ_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + mpool_pkg::MQ_CNT_W'(1);
        2'b01:   count_r <= count_r - mpool_pkg::MQ_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpool_back.sv
// Back end: band line buffer update and the output result queue.
`timescale 1ns / 1ps
`default_nettype none

module mpool_back (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire mpool_pkg::span_q_t                        q_status,
  output logic                                           q_pop,
  input  wire logic                                      out_pop,
  output logic                                           out_empty,
  output logic signed [mpool_pkg::SAMPLE_BITS-1:0]       out_max_value,
  output logic                                           out_map_done
);

  localparam int SB = mpool_pkg::SAMPLE_BITS;

  mpool_pkg::span_t    b_entry_r;
  logic                b_valid_r;
  logic                lw_valid_r;
  logic [mpool_pkg::COL_W-1:0] lw_addr_r;
  logic signed [SB-1:0] lw_data_r;
  logic [SB-1:0]        ram_rd;
  logic signed [SB-1:0] operand, band_new;

  mpool_pkg::result_t oq_r [mpool_pkg::OQ_DEPTH];
  logic [mpool_pkg::OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [mpool_pkg::OQ_CNT_W-1:0] oq_cnt_r;
  logic oq_push, oq_pop;

  // Issue only with room for everything already in flight.
  assign q_pop = q_status.valid &&
                 ((oq_cnt_r + mpool_pkg::OQ_CNT_W'(b_valid_r)) <
                  mpool_pkg::OQ_CNT_W'(mpool_pkg::OQ_DEPTH));

  mpool_ram #(
    .WIDTH (SB),
    .DEPTH (mpool_pkg::MAX_COLS)
  ) u_line (
    .clk     (clk),
    .wr_en   (b_valid_r),
    .wr_addr (b_entry_r.oc),
    .wr_data (band_new),
    .rd_addr (q_status.head.oc),
    .rd_data (ram_rd)
  );

  // Bypass the write that landed on the same edge as this read.
  assign operand  = (lw_valid_r && lw_addr_r == b_entry_r.oc) ? lw_data_r : $signed(ram_rd);
  assign band_new = (b_entry_r.first_row || $signed(b_entry_r.value) > operand) ?
                    b_entry_r.value : operand;

  assign oq_push = b_valid_r && b_entry_r.band_end;
  assign out_empty = oq_cnt_r == '0;
  assign oq_pop    = out_pop && !out_empty;
  assign out_max_value = oq_r[oq_rd_r].value;
  assign out_map_done  = oq_r[oq_rd_r].map_done;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_entry_r <= q_status.head;
    end
    lw_addr_r <= b_entry_r.oc;
    lw_data_r <= band_new;
    if (oq_push) begin
      oq_r[oq_wr_r] <= '{value: band_new, map_done: b_entry_r.map_done};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      lw_valid_r <= 1'b0;
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      b_valid_r  <= q_pop;
      lw_valid_r <= b_valid_r;
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + mpool_pkg::OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + mpool_pkg::OQ_PTR_W'(1);
      end
      case ({oq_push, oq_pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + mpool_pkg::OQ_CNT_W'(1);
        2'b01:   oq_cnt_r <= oq_cnt_r - mpool_pkg::OQ_CNT_W'(1);
        default: oq_cnt_r <= oq_cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/max_pool_2d_stream.sv
// Top level of the streaming non-overlapping 2D max-pooling block.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-----------------------------
//  config  | cfg_wr_en, cfg_index, cfg_wr_data        | write when cfg_wr_en is high
//  input   | in_push, in_full, in_sample              | take when push && !full
//  result  | out_pop, out_empty, out_max_value,       | take when pop && !empty
//          | out_map_done                             |
//
// One sample is taken per clock while in_full is low and cfg_wr_en is low. The
// span that closes a window is written into the span queue, then moved out of
// it into the back end span register while the line buffer is read, then
// compared, written back and loaded into the output queue, and out_empty falls.
// Reset (synchronous, rst_n low) restores 28 x 28 maps with 2 x 2 windows and
// empties both queues; the line buffer is not cleared, since the first row of
// every band writes its entries before they are read.
// A full output queue stops the back end, the span queue then fills and
// in_full rises; each side stalls on its own.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2d_stream (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      cfg_wr_en,
  input  wire logic [mpool_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [mpool_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
  input  wire logic                                      in_push,
  output logic                                           in_full,
  input  wire logic signed [mpool_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic                                           out_empty,
  input  wire logic                                      out_pop,
  output logic signed [mpool_pkg::SAMPLE_BITS-1:0]       out_max_value,
  output logic                                           out_map_done
);

  // Front to queue: finished row spans of a window.
  logic               q_full;
  logic               q_push;
  mpool_pkg::span_t   q_entry;

  // Queue to back: head of the span queue.
  mpool_pkg::span_q_t q_status;
  logic               q_pop;

  // Count positions, track the running maximum along a window row.
  mpool_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_sample   (in_sample),
    .in_full     (in_full),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // Decouple the counters from the line buffer pipeline.
  mpool_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .status     (q_status)
  );

  // Merge spans into the band line buffer, emit finished windows.
  mpool_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_max_value (out_max_value),
    .out_map_done  (out_map_done)
  );

endmodule

`default_nettype wire
